### rtl/cpdc_pkg.sv
// Shared types, codes and reset constants for the door access controller.
package cpdc_pkg;

  localparam int unsigned CardIdW    = 32;
  localparam int unsigned BytesW     = 4;
  localparam int unsigned EchoW      = 15;
  localparam int unsigned WaitW      = 16;
  localparam int unsigned DutyW      = 13;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AddrW      = 5;

  localparam logic [BytesW-1:0]  CardIdBytes     = 4'd4;
  localparam logic [WaitW-1:0]   ElapsedMax      = 16'hFFFF;
  localparam logic [CardIdW-1:0] FirstIdReset    = 32'h59EF_A003;
  localparam logic [CardIdW-1:0] SecondIdReset   = 32'h4935_217A;
  localparam logic [WaitW-1:0]   WaitLimitReset  = 16'd5000;
  localparam logic [EchoW-1:0]   NearLimitReset  = 15'd1166;
  localparam logic [DutyW-1:0]   ClosedDutyReset = 13'd205;
  localparam logic [DutyW-1:0]   OpenDutyReset   = 13'd1024;

  typedef enum logic [1:0] {
    ACT_CARD = 2'd0,
    ACT_POLL = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_GRANTED = 3'd1,
    ST_DENIED  = 3'd2,
    ST_WAITING = 3'd3,
    ST_OPEN    = 3'd4,
    ST_CLOSED  = 3'd5,
    ST_TIMEOUT = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    REG_FIRST_ID   = 3'd0,
    REG_SECOND_ID  = 3'd1,
    REG_WAIT_LIMIT = 3'd2,
    REG_NEAR_LIMIT = 3'd3,
    REG_CLOSED     = 3'd4,
    REG_OPEN       = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WAIT = 3'b010,
    S_OPEN = 3'b100
  } door_state_e;

  typedef struct packed {
    logic [CardIdW-1:0] first_id;
    logic [CardIdW-1:0] second_id;
    logic [WaitW-1:0]   wait_limit;
    logic [EchoW-1:0]   near_limit;
    logic [DutyW-1:0]   closed_duty;
    logic [DutyW-1:0]   open_duty;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [CardIdW-1:0] card_id;
    logic [BytesW-1:0]  card_id_bytes;
    logic [EchoW-1:0]   echo_width_us;
    logic               echo_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [DutyW-1:0] servo_duty;
    logic             door_is_open;
    logic             awaiting_person;
    logic             cancelled_wait;
  } result_t;

endpackage

### rtl/cpdc_regs.sv
// Configuration register file behind the APB-style port.
module cpdc_regs import cpdc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FIRST_ID:   cfg_d.first_id    = pwdata[CardIdW-1:0];
        REG_SECOND_ID:  cfg_d.second_id   = pwdata[CardIdW-1:0];
        REG_WAIT_LIMIT: cfg_d.wait_limit  = pwdata[WaitW-1:0];
        REG_NEAR_LIMIT: cfg_d.near_limit  = pwdata[EchoW-1:0];
        REG_CLOSED:     cfg_d.closed_duty = pwdata[DutyW-1:0];
        REG_OPEN:       cfg_d.open_duty   = pwdata[DutyW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIRST_ID:   prdata = cfg_q.first_id;
      REG_SECOND_ID:  prdata = cfg_q.second_id;
      REG_WAIT_LIMIT: prdata = {{(DataW-WaitW){1'b0}}, cfg_q.wait_limit};
      REG_NEAR_LIMIT: prdata = {{(DataW-EchoW){1'b0}}, cfg_q.near_limit};
      REG_CLOSED:     prdata = {{(DataW-DutyW){1'b0}}, cfg_q.closed_duty};
      REG_OPEN:       prdata = {{(DataW-DutyW){1'b0}}, cfg_q.open_duty};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_id    <= FirstIdReset;
      cfg_q.second_id   <= SecondIdReset;
      cfg_q.wait_limit  <= WaitLimitReset;
      cfg_q.near_limit  <= NearLimitReset;
      cfg_q.closed_duty <= ClosedDutyReset;
      cfg_q.open_duty   <= OpenDutyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/cpdc_core.sv
// Door state machine, wait timer and per-item result logic.
module cpdc_core import cpdc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  door_state_e state_q, state_d;
  logic [WaitW-1:0] elapsed_q, elapsed_d;
  logic [2:0]       status;
  logic             cancelled;
  logic             card_ok;
  logic             near;
  logic             door;

  assign card_ok = (item_i.card_id_bytes == CardIdBytes) &&
                   ((item_i.card_id == cfg_i.first_id) ||
                    (item_i.card_id == cfg_i.second_id));
  assign near = item_i.echo_ok && (item_i.echo_width_us != '0) &&
                (item_i.echo_width_us <= cfg_i.near_limit);

  always_comb begin
    state_d   = state_q;
    elapsed_d = elapsed_q;
    status    = ST_NONE;
    cancelled = 1'b0;
    case (item_i.action)
      ACT_CARD: begin
        cancelled = (state_q != S_IDLE);
        if (card_ok) begin
          state_d   = S_WAIT;
          elapsed_d = '0;
          status    = ST_GRANTED;
        end else begin
          state_d = S_IDLE;
          status  = ST_DENIED;
        end
      end
      ACT_POLL: begin
        case (state_q)
          S_WAIT: begin
            if (elapsed_q > cfg_i.wait_limit) begin
              state_d = S_IDLE;
              status  = ST_TIMEOUT;
            end else if (near) begin
              state_d = S_OPEN;
              status  = ST_OPEN;
            end else begin
              status = ST_WAITING;
            end
          end
          S_OPEN: begin
            if (!near) begin
              state_d = S_IDLE;
              status  = ST_CLOSED;
            end
          end
          default: state_d = state_q;
        endcase
      end
      ACT_TICK: begin
        if (elapsed_q != ElapsedMax) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end
      default: state_d = state_q;
    endcase
  end

  assign door                  = (state_d == S_OPEN);
  assign res_o.status          = status;
  assign res_o.servo_duty      = door ? cfg_i.open_duty : cfg_i.closed_duty;
  assign res_o.door_is_open    = door;
  assign res_o.awaiting_person = (state_d != S_IDLE);
  assign res_o.cancelled_wait  = cancelled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      elapsed_q <= '0;
    end else if (adv_i) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

### rtl/card_and_proximity_door_controller.sv
// Top level of the card and proximity door controller.
// Path: an input is held in the input register, its result in the result register.
// Throughput: one item per cycle; a stalled result holds the result register,
// and the input stalls only once the input register is also full.
// Reset: asynchronous, active low; idle, door closed, timer zero,
// registers at their defaults.
module card_and_proximity_door_controller import cpdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [CardIdW-1:0] card_id_i,
  input  logic [BytesW-1:0]  card_id_bytes_i,
  input  logic [EchoW-1:0]   echo_width_us_i,
  input  logic               echo_ok_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [DutyW-1:0]   servo_duty_o,
  output logic               door_is_open_o,
  output logic               awaiting_person_o,
  output logic               cancelled_wait_o
);

  cfg_t    cfg;
  item_t   item_q, item_d;
  result_t res, res_q;
  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  logic    out_take;
  logic    s1_adv;

  cpdc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpdc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (s1_adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_take   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_take;
  assign in_ready_o = !s1_valid_q || out_take;

  assign item_d.action        = action_i;
  assign item_d.card_id       = card_id_i;
  assign item_d.card_id_bytes = card_id_bytes_i;
  assign item_d.echo_width_us = echo_width_us_i;
  assign item_d.echo_ok       = echo_ok_i;

  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = out_take ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
    if (s1_adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign servo_duty_o      = res_q.servo_duty;
  assign door_is_open_o    = res_q.door_is_open;
  assign awaiting_person_o = res_q.awaiting_person;
  assign cancelled_wait_o  = res_q.cancelled_wait;

endmodule

### rtl/cpdc_checker.sv
// Port-level checks for the door controller, bound to the top level.
module cpdc_checker import cpdc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       status_o,
  input logic [DutyW-1:0] servo_duty_o,
  input logic             door_is_open_o,
  input logic             awaiting_person_o,
  input logic             cancelled_wait_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(status_o) && $stable(servo_duty_o))
    else $error("result changed while stalled");

  a_open_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && door_is_open_o |-> awaiting_person_o)
    else $error("door open outside the wait state");

  a_grant_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_GRANTED) |-> awaiting_person_o && !door_is_open_o)
    else $error("grant did not enter the wait state with the door closed");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_DENIED) || (status_o == ST_TIMEOUT) ||
                    (status_o == ST_CLOSED)) |-> !awaiting_person_o && !door_is_open_o)
    else $error("closing status left the block active");

  a_cancel_card: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cancelled_wait_o |->
      (status_o == ST_GRANTED) || (status_o == ST_DENIED))
    else $error("cancel flag on a non-card result");

endmodule

bind card_and_proximity_door_controller cpdc_checker u_cpdc_checker (.*);
